@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cuckoo hash table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define CHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that also holds across reset.
`define CHT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Types, field widths and codes shared by the cuckoo hash table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

   localparam int KEY_W      = 31;
   localparam int ENTRY_W    = KEY_W + 1;
   localparam int OCC_W      = 12;
   localparam int STATUS_W   = 2;
   localparam int SIZE_W     = 4;
   localparam int KICK_W     = 8;
   localparam int LG_W       = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_W      = 32;
   localparam int RSP_W      = 48;

   localparam logic [1:0] HASH_DELTA = 2'd3;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_KICK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG2  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KICK_LIMIT = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_LOG2_RST  = 4'd10;
   localparam logic [KICK_W-1:0] KICK_LIMIT_RST = 8'd32;

   typedef struct packed {
      logic [LG_W-1:0]   size_lg;     // clamped to 1..LOG_SLOTS
      logic [KICK_W-1:0] kick_limit;
   } cfg_type;

endpackage

@@ rtl/cuckoo_hash_table.sv @@
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-way cuckoo hash table of 31-bit keys held in two synchronous RAMs.
// After reset the block sweeps both tables clear, one slot per cycle;
// req_tready stays low during the sweep while configuration writes are
// taken. Every transaction then runs through one sequencer around the two
// registered RAM read ports: a search reads both tables and answers from
// that read, as does an insert that finds its table-one slot free or is
// refused at half load, and each displacement round reads both tables,
// writes table one, reads both tables again and writes table two. A new
// request is taken as soon as the sequencer is back in idle, even while
// the previous response waits on rsp_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cuckoo_hash_table #(
   parameter int LOG_SLOTS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: key[30:0], zero[31]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cht_pkg::REQ_W-1:0]         req_tdata,
   // req_tuser: req_type[0]
   input  logic                              req_tuser,
   // rsp_tdata: found[0], status[2:1], homeless_key[33:3], occupancy[45:34],
   // zero[47:46]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cht_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cht_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cht_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = LOG_SLOTS;
   localparam int SLOTS  = 1 << LOG_SLOTS;
   localparam int CNT_W  = (LOG_SLOTS > cht_pkg::OCC_W) ? LOG_SLOTS : cht_pkg::OCC_W;
   localparam logic [ADDR_W-1:0] DELTA = ADDR_W'(cht_pkg::HASH_DELTA);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LOOK  = 6'b000100,
      ST_EVAL  = 6'b001000,
      ST_KREAD = 6'b010000,
      ST_KEVAL = 6'b100000
   } state_type;

   cht_pkg::cfg_type cfg;

   state_type                     state_ff, state_in;
   logic [ADDR_W-1:0]             clr_addr_ff, clr_addr_in;
   logic [cht_pkg::KEY_W-1:0]     hand_ff, hand_in;
   logic                          type_ff, type_in;
   logic [cht_pkg::KICK_W-1:0]    round_ff, round_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          found_ff, found_in;
   logic [cht_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [cht_pkg::KEY_W-1:0]     homeless_ff, homeless_in;
   logic [cht_pkg::OCC_W-1:0]     occ_ff, occ_in;

   logic                          t1_we, t1_re, t2_we, t2_re;
   logic [ADDR_W-1:0]             t1_waddr, t1_raddr, t2_waddr, t2_raddr;
   logic [cht_pkg::ENTRY_W-1:0]   t1_wdata, t2_wdata, t1_rdata, t2_rdata;

   logic [ADDR_W-1:0]             mask, p, q, req_p, req_q;
   logic [CNT_W-1:0]              half, count_inc;
   logic [cht_pkg::ENTRY_W-1:0]   hand_entry;
   logic                          out_free, accept, load, full, limit_hit;

   cht_csr #(.LOG_SLOTS(LOG_SLOTS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cht_ram #(.WIDTH(cht_pkg::ENTRY_W), .DEPTH(SLOTS)) u_first_table (
      .clock (clock),
      .we    (t1_we),
      .waddr (t1_waddr),
      .wdata (t1_wdata),
      .re    (t1_re),
      .raddr (t1_raddr),
      .rdata (t1_rdata)
   );

   cht_ram #(.WIDTH(cht_pkg::ENTRY_W), .DEPTH(SLOTS)) u_second_table (
      .clock (clock),
      .we    (t2_we),
      .waddr (t2_waddr),
      .wdata (t2_wdata),
      .re    (t2_re),
      .raddr (t2_raddr),
      .rdata (t2_rdata)
   );

   assign mask       = ~({ADDR_W{1'b1}} << cfg.size_lg);
   assign half       = CNT_W'(1) << (cfg.size_lg - cht_pkg::LG_W'(1));
   assign p          = hand_ff[ADDR_W-1:0] & mask;
   assign q          = (p ^ DELTA) & mask;
   assign req_p      = req_tdata[ADDR_W-1:0] & mask;
   assign req_q      = (req_p ^ DELTA) & mask;
   assign hand_entry = {1'b1, hand_ff};
   assign count_inc  = count_ff + CNT_W'(1);
   assign full       = count_ff >= half;
   assign limit_hit  = round_ff == cfg.kick_limit;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      hand_in     = hand_ff;
      type_in     = type_ff;
      round_in    = round_ff;
      count_in    = count_ff;
      load        = 1'b0;
      found_in    = 1'b0;
      status_in   = cht_pkg::STATUS_DONE;
      homeless_in = '0;
      t1_we       = 1'b0;
      t1_waddr    = p;
      t1_wdata    = hand_entry;
      t1_re       = 1'b0;
      t1_raddr    = p;
      t2_we       = 1'b0;
      t2_waddr    = q;
      t2_wdata    = hand_entry;
      t2_re       = 1'b0;
      t2_raddr    = q;

      unique case (state_ff)
         ST_CLEAR: begin
            t1_we    = 1'b1;
            t1_waddr = clr_addr_ff;
            t1_wdata = '0;
            t2_we    = 1'b1;
            t2_waddr = clr_addr_ff;
            t2_wdata = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            t1_raddr = req_p;
            t2_raddr = req_q;
            if (accept) begin
               t1_re    = 1'b1;
               t2_re    = 1'b1;
               hand_in  = req_tdata[cht_pkg::KEY_W-1:0];
               type_in  = req_tuser;
               round_in = '0;
               state_in = ST_EVAL;
            end
         end
         ST_LOOK: begin
            t1_re    = 1'b1;
            t2_re    = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (type_ff == cht_pkg::REQ_SEARCH) begin
               if (out_free) begin
                  load     = 1'b1;
                  found_in = (t1_rdata == hand_entry) || (t2_rdata == hand_entry);
                  state_in = ST_IDLE;
               end
            end else if (round_ff == '0 && full) begin
               if (out_free) begin
                  load      = 1'b1;
                  status_in = cht_pkg::STATUS_FULL;
                  state_in  = ST_IDLE;
               end
            end else if (!t1_rdata[cht_pkg::KEY_W] && !(limit_hit && round_ff != '0)) begin
               if (out_free) begin
                  t1_we    = 1'b1;
                  count_in = count_inc;
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (limit_hit) begin
               if (out_free) begin
                  load        = 1'b1;
                  status_in   = cht_pkg::STATUS_KICK;
                  homeless_in = hand_ff;
                  state_in    = ST_IDLE;
               end
            end else begin
               // evict table-one occupant
               t1_we    = 1'b1;
               hand_in  = t1_rdata[cht_pkg::KEY_W-1:0];
               state_in = ST_KREAD;
            end
         end
         ST_KREAD: begin
            t1_re    = 1'b1;
            t2_re    = 1'b1;
            state_in = ST_KEVAL;
         end
         ST_KEVAL: begin
            if (!t1_rdata[cht_pkg::KEY_W]) begin
               if (out_free) begin
                  t1_we    = 1'b1;
                  count_in = count_inc;
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!t2_rdata[cht_pkg::KEY_W]) begin
               if (out_free) begin
                  t2_we    = 1'b1;
                  count_in = count_inc;
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               t2_we    = 1'b1;
               hand_in  = t2_rdata[cht_pkg::KEY_W-1:0];
               round_in = round_ff + cht_pkg::KICK_W'(1);
               state_in = ST_LOOK;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      occ_in = count_in[cht_pkg::OCC_W-1:0];
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hand_ff  <= hand_in;
      type_ff  <= type_in;
      round_ff <= round_in;
      if (load) begin
         found_ff    <= found_in;
         status_ff   <= status_in;
         homeless_ff <= homeless_in;
         occ_ff      <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, occ_ff, homeless_ff, status_ff, found_ff};

endmodule

@@ rtl/cht_ram.sv @@
// ----------------------------------------------------------------------------
// cht_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/cht_csr.sv @@
// ----------------------------------------------------------------------------
// cht_csr
// Configuration registers: table size and displacement limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_csr #(
   parameter int LOG_SLOTS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cht_pkg::CSR_DATA_W-1:0]   csr_data,
   output cht_pkg::cfg_type                 cfg
);

   logic [cht_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [cht_pkg::KICK_W-1:0] kick_ff, kick_in;
   logic [cht_pkg::LG_W-1:0]   size_ext;

   assign csr_ready = 1'b1;

   always_comb begin
      size_in = size_ff;
      kick_in = kick_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cht_pkg::CSR_SIZE_LOG2:  size_in = csr_data[cht_pkg::SIZE_W-1:0];
            cht_pkg::CSR_KICK_LIMIT: kick_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= cht_pkg::SIZE_LOG2_RST;
         kick_ff <= cht_pkg::KICK_LIMIT_RST;
      end else begin
         size_ff <= size_in;
         kick_ff <= kick_in;
      end
   end

   assign size_ext = {1'b0, size_ff};

   always_comb begin
      if (size_ext == '0) begin
         cfg.size_lg = cht_pkg::LG_W'(1);
      end else if (size_ext > cht_pkg::LG_W'(LOG_SLOTS)) begin
         cfg.size_lg = cht_pkg::LG_W'(LOG_SLOTS);
      end else begin
         cfg.size_lg = size_ext;
      end
      cfg.kick_limit = kick_ff;
   end

endmodule

@@ rtl/cht_checker.sv @@
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the cuckoo hash table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cht_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cht_pkg::RSP_W-1:0]       rsp_tdata
);

   `CHT_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready, "outputs active after reset")

   `CHT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "response changed while stalled")

   `CHT_ASSERT(a_homeless_zero, clock, reset, rsp_tvalid && rsp_tdata[2:1] != cht_pkg::STATUS_KICK |-> rsp_tdata[33:3] == '0, "homeless key set without kick status")

   `CHT_ASSERT(a_found_done, clock, reset, rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2:1] == cht_pkg::STATUS_DONE, "hit reported with non-done status")

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (.*);

@@ bench/cuckoo_hash_table_tb.sv @@
// ----------------------------------------------------------------------------
// cuckoo_hash_table_tb
// Self-checking bench for the two-way cuckoo hash table. A short scripted
// sequence walks the reset state, size clamping, half-load refusal, the
// homeless-key return and displacement into a slot left empty by a size change.
// Random phases then grow the table through several sizes and kick limits with
// mostly well-formed insert/search traffic. Typed script steps are checked as
// written, the rest against a bit-accurate predictor of tables and key count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cuckoo_hash_table_tb;

   localparam int LOG_SLOTS   = 10;
   localparam int SLOTS       = 1 << LOG_SLOTS;
   localparam int QUIET_LIMIT = 20000;
   localparam logic [cht_pkg::KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [cht_pkg::OCC_W-1:0]    occupancy;
      logic [cht_pkg::KEY_W-1:0]    homeless_key;
      logic [cht_pkg::STATUS_W-1:0] status;
      logic                         found;
   } reply_type;

   typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [0:0]                sel;     // req type for items, register index for writes
      logic [cht_pkg::KEY_W-1:0] value;
      logic                      typed;
      reply_type                 want;
   } script_step_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [cht_pkg::REQ_W-1:0]      req_tdata  = '0;
   logic                           req_tuser  = cht_pkg::REQ_INSERT;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cht_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [cht_pkg::CSR_IDX_W-1:0]  csr_index  = cht_pkg::CSR_SIZE_LOG2;
   logic [cht_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   cuckoo_hash_table #(.LOG_SLOTS(LOG_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [cht_pkg::ENTRY_W-1:0] slot_one [SLOTS];
   logic [cht_pkg::ENTRY_W-1:0] slot_two [SLOTS];
   int unsigned                 key_count;
   logic [cht_pkg::SIZE_W-1:0]  size_code;
   logic [cht_pkg::KICK_W-1:0]  kick_cap;

   reply_type                   pending_replies [$];
   logic [cht_pkg::KEY_W-1:0]   key_pool [$];
   script_step_type             script [$];

   int  errors       = 0;
   int  replies_seen = 0;
   int  n_insert     = 0;
   int  n_search     = 0;
   int  n_hits       = 0;
   int  n_refused    = 0;
   int  n_homeless   = 0;
   int  peak_occ     = 0;
   int  quiet_cycles = 0;
   bit  calm         = 1'b0;
   bit  long_hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic reply_type hash_apply(input logic req_type,
                                            input logic [cht_pkg::KEY_W-1:0] key);
      reply_type                   r;
      int                          lg;
      int unsigned                 mask, half, p, q, rounds;
      logic [cht_pkg::ENTRY_W-1:0] old;
      logic [cht_pkg::KEY_W-1:0]   hand;
      bit                          placed;
      r = '0;
      placed = 1'b0;
      lg = size_code;
      if (lg < 1) lg = 1;
      if (lg > LOG_SLOTS) lg = LOG_SLOTS;
      mask = (1 << lg) - 1;
      half = 1 << (lg - 1);
      if (req_type == cht_pkg::REQ_SEARCH) begin
         p = key & mask;
         q = (p ^ cht_pkg::HASH_DELTA) & mask;
         r.found = (slot_one[p] == {1'b1, key}) || (slot_two[q] == {1'b1, key});
      end else if (key_count >= half) begin
         r.status = cht_pkg::STATUS_FULL;
      end else begin
         hand = key;
         p = hand & mask;
         if (!slot_one[p][cht_pkg::KEY_W]) begin
            slot_one[p] = {1'b1, hand};
            key_count++;
            placed = 1'b1;
         end
         for (rounds = 0; rounds < kick_cap && !placed; rounds++) begin
            // first slot recomputed from the key in hand every round
            p = hand & mask;
            old = slot_one[p];
            slot_one[p] = {1'b1, hand};
            if (!old[cht_pkg::KEY_W]) begin
               key_count++;
               placed = 1'b1;
            end else begin
               hand = old[cht_pkg::KEY_W-1:0];
               p = hand & mask;
               if (!slot_one[p][cht_pkg::KEY_W]) begin
                  slot_one[p] = {1'b1, hand};
                  key_count++;
                  placed = 1'b1;
               end else begin
                  q = (p ^ cht_pkg::HASH_DELTA) & mask;
                  old = slot_two[q];
                  slot_two[q] = {1'b1, hand};
                  if (!old[cht_pkg::KEY_W]) begin
                     key_count++;
                     placed = 1'b1;
                  end else begin
                     hand = old[cht_pkg::KEY_W-1:0];
                  end
               end
            end
         end
         if (!placed) begin
            r.status = cht_pkg::STATUS_KICK;
            r.homeless_key = hand;
         end
      end
      r.occupancy = key_count[cht_pkg::OCC_W-1:0];
      return r;
   endfunction

   function automatic script_step_type step(input step_kind_type kind, input logic sel,
                                            input logic [cht_pkg::KEY_W-1:0] value,
                                            input logic typed, input logic found,
                                            input logic [cht_pkg::STATUS_W-1:0] status,
                                            input logic [cht_pkg::KEY_W-1:0] homeless,
                                            input logic [cht_pkg::OCC_W-1:0] occ);
      script_step_type s;
      s.kind = kind;
      s.sel = sel;
      s.value = value;
      s.typed = typed;
      s.want.found = found;
      s.want.status = status;
      s.want.homeless_key = homeless;
      s.want.occupancy = occ;
      return s;
   endfunction

   task automatic send_item(input logic req_type, input logic [cht_pkg::KEY_W-1:0] key,
                            input logic typed, input reply_type want);
      reply_type pred;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, key};
      req_tuser <= req_type;
      do @(posedge clock); while (!req_tready);
      pred = hash_apply(req_type, key);
      pending_replies.push_back(typed ? want : pred);
      if (req_type == cht_pkg::REQ_INSERT) begin
         n_insert++;
         key_pool.push_back(key);
         if (key_pool.size() > 64) void'(key_pool.pop_front());
      end else begin
         n_search++;
      end
   endtask

   // registers are only written with the block idle
   task automatic write_csr(input logic [cht_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cht_pkg::CSR_DATA_W-1:0] data);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == cht_pkg::CSR_SIZE_LOG2) size_code = data[cht_pkg::SIZE_W-1:0];
      else kick_cap = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [cht_pkg::SIZE_W-1:0] size_lg,
                            input logic [cht_pkg::KICK_W-1:0] kick,
                            input int count, input int calm_from);
      logic [cht_pkg::KEY_W-1:0] key;
      logic                      req_type;
      int                        pick;
      write_csr(cht_pkg::CSR_SIZE_LOG2, {4'($urandom), size_lg});
      write_csr(cht_pkg::CSR_KICK_LIMIT, kick);
      for (int i = 0; i < count; i++) begin
         if (i >= calm_from) calm = 1'b1;
         req_type = ($urandom_range(0, 99) < 55) ? cht_pkg::REQ_INSERT : cht_pkg::REQ_SEARCH;
         key = 31'($urandom);
         pick = $urandom_range(0, 9);
         if (key_pool.size() != 0) begin
            if (req_type == cht_pkg::REQ_SEARCH && pick < 6) begin
               key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else if (req_type == cht_pkg::REQ_INSERT && pick < 2) begin
               key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else if (req_type == cht_pkg::REQ_INSERT && pick < 5) begin
               // same low bits as a stored key: provokes displacement chains
               key = (key & 31'h7FFF_FC00) |
                     (key_pool[$urandom_range(0, key_pool.size() - 1)] & 31'h3FF);
            end
         end
         send_item(req_type, key, 1'b0, '0);
      end
   endtask

   // reply side: check, then choose tready for the next cycle
   initial begin
      reply_type got, want;
      int        stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(reply_type)-1:0];
            replies_seen++;
            if (got.status == cht_pkg::STATUS_FULL) n_refused++;
            if (got.status == cht_pkg::STATUS_KICK) n_homeless++;
            if (got.found) n_hits++;
            if (got.occupancy > peak_occ) peak_occ = got.occupancy;
            if (pending_replies.size() == 0) begin
               $display("%0t: reply with none expected: exp none got %h", $time, got);
               errors++;
            end else begin
               want = pending_replies.pop_front();
               if (got.found !== want.found) begin
                  $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                  errors++;
               end
               if (got.homeless_key !== want.homeless_key) begin
                  $display("%0t: homeless_key exp %h got %h", $time,
                           want.homeless_key, got.homeless_key);
                  errors++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $display("%0t: occupancy exp %0d got %0d", $time,
                           want.occupancy, got.occupancy);
                  errors++;
               end
            end
         end
         if (replies_seen == 300 && !long_hold_done) begin
            // long back-pressure so the request side stalls
            long_hold_done = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL cuckoo_hash_table");
         $finish;
      end
   end

   initial begin
      foreach (slot_one[i]) begin
         slot_one[i] = '0;
         slot_two[i] = '0;
      end
      key_count = 0;
      size_code = cht_pkg::SIZE_LOG2_RST;
      kick_cap = cht_pkg::KICK_LIMIT_RST;

      // reset state, clamping, half load, homeless key, duplicates
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, '0, 1, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, KEY_MAX, 1, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_CFG, cht_pkg::CSR_KICK_LIMIT, 31'h00, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_CFG, cht_pkg::CSR_SIZE_LOG2, 31'hF0, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, KEY_MAX, 1, 0,
                            cht_pkg::STATUS_DONE, '0, 1));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, '0, 1, 0,
                            cht_pkg::STATUS_FULL, '0, 1));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, KEY_MAX, 1, 1,
                            cht_pkg::STATUS_DONE, '0, 1));
      script.push_back(step(STEP_CFG, cht_pkg::CSR_SIZE_LOG2, 31'h0F, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, KEY_MAX, 1, 0,
                            cht_pkg::STATUS_DONE, '0, 2));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, 31'h3FF, 1, 0,
                            cht_pkg::STATUS_KICK, 31'h3FF, 2));
      script.push_back(step(STEP_CFG, cht_pkg::CSR_KICK_LIMIT, 31'hFF, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, 31'h3FF, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, KEY_MAX, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, 31'h3FF, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_CFG, cht_pkg::CSR_SIZE_LOG2, 31'h01, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, 31'h5, 1, 0,
                            cht_pkg::STATUS_FULL, '0, 3));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, KEY_MAX, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      // grown size: evicted key lands in an empty first slot
      script.push_back(step(STEP_CFG, cht_pkg::CSR_SIZE_LOG2, 31'h03, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, 31'h1, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, 31'h1, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, KEY_MAX, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_INSERT, 31'h2AAA_AAAA, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));
      script.push_back(step(STEP_ITEM, cht_pkg::REQ_SEARCH, 31'h5555_5555, 0, 0,
                            cht_pkg::STATUS_DONE, '0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CFG)
            write_csr(script[i].sel, script[i].value[cht_pkg::CSR_DATA_W-1:0]);
         else
            send_item(script[i].sel, script[i].value, script[i].typed, script[i].want);
      end

      run_phase(4'd2, 8'd1, 60, 60);
      run_phase(4'd4, 8'd1, 120, 120);
      run_phase(4'd5, 8'd2, 150, 150);
      run_phase(4'd6, 8'd255, 150, 150);
      run_phase(4'd7, 8'd8, 200, 200);
      run_phase(4'd8, 8'd3, 250, 250);
      run_phase(4'd9, 8'd16, 300, 300);
      run_phase(4'd12, 8'd64, 700, 400);

      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("%0d inserts, %0d searches (%0d hits) over sizes 1..10, kick limits 0..255",
               n_insert, n_search, n_hits);
      $display("%0d refused at half load, %0d homeless keys, peak occupancy %0d",
               n_refused, n_homeless, peak_occ);
      if (errors == 0)
         $display("PASS cuckoo_hash_table");
      else
         $display("FAIL cuckoo_hash_table");
      $finish;
   end

endmodule
